@@ rtl/sctc_pkg.sv @@
// Shared types, key codes and layout tables for the scan code to character unit.
`default_nettype none

package sctc_pkg;

   localparam int SCTC_FIFO_DEPTH = 128;
   localparam int NUM_LAYOUTS     = 2;
   localparam int TBL_LEN         = 58;
   localparam int PAD_LEN         = 13;

   localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
   localparam logic [7:0] KEY_RSHIFT  = 8'h36;
   localparam logic [7:0] KEY_CAPS    = 8'h3A;
   localparam logic [7:0] KEY_NUM     = 8'h45;
   localparam logic [7:0] KEY_PREFIX  = 8'hE0;
   localparam logic [7:0] KEY_SLASH   = 8'h35;
   localparam logic [7:0] KEY_ENTER   = 8'h1C;
   localparam logic [7:0] KEY_ANGLE   = 8'h56;
   localparam logic [7:0] PAD_FIRST   = 8'h47;
   localparam logic [7:0] PAD_LAST    = 8'h53;
   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam logic [7:0] CODE_MASK   = 8'h7F;

   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;
   localparam logic [7:0] CH_LESS     = 8'h3C;
   localparam logic [7:0] CH_GREATER  = 8'h3E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CASE_DELTA  = 8'h20;

   localparam logic [7:0] PLAIN_TBL [2][TBL_LEN] = '{
      '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h5C, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h5C, 8'h2E, 8'h38, 8'h20},
      '{8'h00, 8'hB3, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h27, 8'hA8, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h1A, 8'h2B, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hA4,
        8'h7B, 8'hB3, 8'h00, 8'h7D, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h5C, 8'h2E, 8'h38, 8'h20}
   };

   localparam logic [7:0] SHIFT_TBL [2][TBL_LEN] = '{
      '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'hB3, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h5C, 8'h2E, 8'h38, 8'h20},
      '{8'h00, 8'hA7, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
        8'h29, 8'h3D, 8'h3F, 8'hAD, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h1A, 8'h2A, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hA5,
        8'h5B, 8'hA7, 8'h2A, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h5C, 8'h2E, 8'h38, 8'h20}
   };

   localparam logic [7:0] PAD_TBL [PAD_LEN] = '{
      8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32,
      8'h33, 8'h30, 8'h2E
   };

   typedef struct packed {
      logic       kind;
      logic [7:0] scan_code;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       was_empty;
   } rsp_type;

   // One queued operation: a host read, or a character push.
   typedef struct packed {
      logic       is_read;
      logic [7:0] ch;
   } op_type;

endpackage

`default_nettype wire

@@ rtl/sctc_front.sv @@
// Front end: keyboard flag state, scan code decode and layout register.
`default_nettype none

module sctc_front
   import sctc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data,
   output logic         op_valid,
   input  wire logic    op_ready,
   output op_type       op_data
);

   logic       language_ff, language_in;
   logic       shift_ff, shift_in;
   logic       caps_ff, caps_in;
   logic       numlock_ff, numlock_in;
   logic       prefix_ff, prefix_in;
   logic       accept;
   logic [7:0] code;
   logic       lay;
   logic [5:0] tbl_idx;
   logic [3:0] pad_idx;
   logic [7:0] tbl_ch;
   logic [7:0] pad_ch;

   assign req_ready = op_ready;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && op_ready;
   assign code      = req_data.scan_code;
   assign lay       = (32'(language_ff) < NUM_LAYOUTS) ? language_ff : 1'b0;
   assign tbl_idx   = code[5:0];
   assign pad_idx   = 4'(code - PAD_FIRST);

   always_comb begin
      logic [7:0] c;
      if (code == KEY_ANGLE) begin
         c = shift_ff ? CH_GREATER : CH_LESS;
      end else if (code < 8'(TBL_LEN)) begin
         c = shift_ff ? SHIFT_TBL[lay][tbl_idx] : PLAIN_TBL[lay][tbl_idx];
      end else begin
         c = '0;
      end
      if (caps_ff) begin
         if (shift_ff && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            c = c + CASE_DELTA;
         end else if (!shift_ff && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            c = c - CASE_DELTA;
         end
      end
      if (prefix_ff && code == KEY_SLASH) begin
         c = CH_SLASH;
      end else if (prefix_ff && code == KEY_ENTER) begin
         c = CH_NEWLINE;
      end
      tbl_ch = c;
   end

   always_comb begin
      logic [7:0] d;
      d = (pad_idx < 4'(PAD_LEN)) ? PAD_TBL[pad_idx] : '0;
      pad_ch = (d >= CH_ZERO && d <= CH_NINE && !numlock_ff) ? d : '0;
   end

   always_comb begin
      language_in = (csr_valid && csr_ready) ? csr_data : language_ff;
      shift_in    = shift_ff;
      caps_in     = caps_ff;
      numlock_in  = numlock_ff;
      prefix_in   = prefix_ff;
      op_valid    = 1'b0;
      op_data     = '0;
      if (accept) begin
         if (req_data.kind) begin
            op_valid        = 1'b1;
            op_data.is_read = 1'b1;
         end else if ((code & RELEASE_BIT) != '0) begin
            if (code == KEY_PREFIX) begin
               prefix_in = 1'b1;
            end
            if ((code & CODE_MASK) == KEY_LSHIFT || (code & CODE_MASK) == KEY_RSHIFT) begin
               shift_in  = 1'b0;
               prefix_in = 1'b0;
            end
         end else begin
            case (code) inside
               KEY_LSHIFT, KEY_RSHIFT: begin
                  shift_in  = 1'b1;
                  prefix_in = 1'b0;
               end
               KEY_NUM: begin
                  numlock_in = !numlock_ff;
               end
               KEY_CAPS: begin
                  caps_in = !caps_ff;
               end
               [PAD_FIRST:PAD_LAST]: begin
                  op_valid   = 1'b1;
                  op_data.ch = pad_ch;
                  prefix_in  = 1'b0;
               end
               [8'd2:8'd25], 8'd28, [8'd30:8'd41], [8'd43:8'd55], 8'd57, KEY_ANGLE: begin
                  op_valid   = 1'b1;
                  op_data.ch = tbl_ch;
                  prefix_in  = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         language_ff <= 1'b0;
         shift_ff    <= 1'b0;
         caps_ff     <= 1'b0;
         numlock_ff  <= 1'b1;
         prefix_ff   <= 1'b0;
      end else begin
         language_ff <= language_in;
         shift_ff    <= shift_in;
         caps_ff     <= caps_in;
         numlock_ff  <= numlock_in;
         prefix_ff   <= prefix_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sctc_queue.sv @@
// Two-entry operation queue between the front end and the character buffer.
`default_nettype none

module sctc_queue
   import sctc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire op_type in_data,
   output logic        out_valid,
   input  wire logic   out_ready,
   output op_type      out_data
);

   op_type     slot_ff [2];
   logic       wr_idx_ff, wr_idx_in;
   logic       rd_idx_ff, rd_idx_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_idx_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_idx_in = push ? !wr_idx_ff : wr_idx_ff;
      rd_idx_in = pop ? !rd_idx_ff : rd_idx_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sctc_back.sv @@
// Back end: character ring buffer, pointers and registered read response.
`default_nettype none

module sctc_back
   import sctc_pkg::*;
#(
   parameter int FIFO_DEPTH = SCTC_FIFO_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   op_valid,
   output logic        op_ready,
   input  wire op_type op_data,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output rsp_type     rsp_data
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [7:0]       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             empty_ff, empty_in;
   logic [7:0]       rd_data_ff;
   logic             out_free;
   logic             do_push;
   logic             do_read;
   logic             is_empty;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign op_ready  = !op_data.is_read || out_free;
   assign do_push   = op_valid && !op_data.is_read;
   assign do_read   = op_valid && op_data.is_read && out_free;
   assign is_empty  = (rptr_ff == wptr_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.char_out  = empty_ff ? 8'h00 : rd_data_ff;
   assign rsp_data.was_empty = empty_ff;

   always_comb begin
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      rsp_valid_in = rsp_valid_ff;
      empty_in     = empty_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (do_read) begin
         rsp_valid_in = 1'b1;
         empty_in     = is_empty;
         if (!is_empty) begin
            rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= 1'b1;
      end else begin
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         rsp_valid_ff <= rsp_valid_in;
         empty_ff     <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= op_data.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (do_read) begin
         rd_data_ff <= mem[rptr_ff];
      end
   end

endmodule

`default_nettype wire

@@ rtl/scancode_to_char_fifo_unit.sv @@
// Top level: set 1 scan code decoder feeding a character ring buffer.
//
// req channel: one transfer per item. kind 0 carries a keyboard scan code
// byte, which updates shift, caps lock, num lock and prefix state and may
// push one character; kind 1 is a host read, which returns exactly one
// rsp transfer with the popped character, or 0 with was_empty set.
// csr channel: writes the layout select (0 US English, 1 Spanish); always
// ready, write only while no item is in flight.
// A read passes through the queue register, then the buffer read register,
// before it completes on rsp. Throughput: one req transfer per cycle while
// rsp does not stall, set by the single buffer write/read port that
// serves one queued operation a cycle.
// The buffer has FIFO_DEPTH entries and overwrites when full; at most
// FIFO_DEPTH-1 are readable, and FIFO_DEPTH unread pushes read as empty.
// Reset: flags return to num lock on, others clear, buffer empties and
// layout returns to US English; buffer contents are not cleared.
// When rsp stalls, the response register holds, pushes queued ahead of a
// waiting read still drain, and req_ready drops once the queue is full.
`default_nettype none

module scancode_to_char_fifo_unit
   import sctc_pkg::*;
#(
   parameter int FIFO_DEPTH = SCTC_FIFO_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   logic   fq_valid;
   logic   fq_ready;
   op_type fq_data;
   logic   qb_valid;
   logic   qb_ready;
   op_type qb_data;

   sctc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .op_valid  (fq_valid),
      .op_ready  (fq_ready),
      .op_data   (fq_data)
   );

   sctc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   sctc_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (qb_valid),
      .op_ready  (qb_ready),
      .op_data   (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/sctc_port_chk.sv @@
// Port-level checker for the scan code to character unit, with its bind.
`default_nettype none

module sctc_port_chk
   import sctc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data,
   input wire logic    csr_valid,
   input wire logic    csr_ready,
   input wire logic    csr_data
);

   logic unused_ok;
   assign unused_ok = req_valid ^ req_ready ^ (^req_data) ^ csr_valid ^ csr_data;

   empty_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_empty |-> rsp_data.char_out == 8'h00)
      else $error("empty read returned a nonzero character");

   no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   csr_always_ready: assert property (@(posedge clock) disable iff (reset)
      unused_ok == unused_ok |-> csr_ready)
      else $error("configuration port not ready");

endmodule

bind scancode_to_char_fifo_unit sctc_port_chk u_port_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the scan code to character FIFO unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sctc_pkg::*;

   localparam int DEPTH         = SCTC_FIFO_DEPTH;
   localparam int IDLE_PCT      = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 120;
   localparam int PRESSURE_ITEMS = 60;

   localparam logic KIND_SCAN = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [7:0] PLAIN_CHARS [2][58] = '{
      '{8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h5C, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h5C, 8'h2E, 8'h38, 8'h20},
      '{8'h00, 8'hB3, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h27, 8'hA8, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h1A, 8'h2B, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hA4,
        8'h7B, 8'hB3, 8'h00, 8'h7D, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h5C, 8'h2E, 8'h38, 8'h20}
   };

   localparam logic [7:0] SHIFTED_CHARS [2][58] = '{
      '{8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'hB3, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h5C, 8'h2E, 8'h38, 8'h20},
      '{8'h00, 8'hA7, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
        8'h29, 8'h3D, 8'h3F, 8'hAD, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h1A, 8'h2A, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hA5,
        8'h5B, 8'hA7, 8'h2A, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h5C, 8'h2E, 8'h38, 8'h20}
   };

   localparam logic [7:0] KEYPAD_CHARS [13] = '{
      8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32,
      8'h33, 8'h30, 8'h2E
   };

   localparam logic [7:0] DIRECTED_CODES [22] = '{
      8'h00, 8'hFF, KEY_LSHIFT, 8'h10, KEY_ANGLE, KEY_LSHIFT | RELEASE_BIT,
      KEY_CAPS, 8'h1E, KEY_RSHIFT, 8'h1E, KEY_RSHIFT | RELEASE_BIT, KEY_CAPS,
      8'h47, KEY_NUM, 8'h47, 8'h4A, KEY_NUM, KEY_PREFIX, KEY_SLASH,
      KEY_PREFIX, KEY_ENTER, 8'h39
   };

   function automatic bit is_printable(int k);
      return (k > 1 && k < 26) || (k > 29 && k < 42) || (k > 42 && k < 56) ||
             k == 28 || k == 57 || k == 86;
   endfunction

   class char_fifo_scoreboard;
      logic        language;
      logic        shift_held, caps_on, numlock_on, prefix_seen;
      logic [7:0]  char_store [DEPTH];
      int unsigned rd_ptr, wr_ptr;
      rsp_type     expected_q [$];
      int unsigned errors;

      function new();
         language    = 1'b0;
         shift_held  = 1'b0;
         caps_on     = 1'b0;
         numlock_on  = 1'b1;
         prefix_seen = 1'b0;
         rd_ptr      = 0;
         wr_ptr      = 0;
         errors      = 0;
         foreach (char_store[i]) char_store[i] = 8'h00;
      endfunction

      function void push_char(logic [7:0] c);
         char_store[wr_ptr] = c;
         wr_ptr = (wr_ptr + 1) % DEPTH;
      endfunction

      function logic [7:0] layout_char(logic [7:0] k);
         logic [7:0] c;
         if (k == KEY_ANGLE)
            c = shift_held ? CH_GREATER : CH_LESS;
         else if (shift_held)
            c = SHIFTED_CHARS[language][k];
         else
            c = PLAIN_CHARS[language][k];
         if (caps_on && shift_held && c >= CH_UPPER_A && c <= CH_UPPER_Z)
            c = c + CASE_DELTA;
         else if (caps_on && !shift_held && c >= CH_LOWER_A && c <= CH_LOWER_Z)
            c = c - CASE_DELTA;
         return c;
      endfunction

      // Returns 1 when the transfer reads, pushes or changes a flag.
      function bit note_request(req_type item);
         logic [7:0] k;
         logic [7:0] c;
         rsp_type    r;
         k = item.scan_code;
         if (item.kind == KIND_READ) begin
            if (rd_ptr == wr_ptr) begin
               r.char_out  = 8'h00;
               r.was_empty = 1'b1;
            end else begin
               r.char_out  = char_store[rd_ptr];
               r.was_empty = 1'b0;
               rd_ptr = (rd_ptr + 1) % DEPTH;
            end
            expected_q.push_back(r);
            return 1'b1;
         end
         if (k[7]) begin
            if (k == KEY_PREFIX) begin
               prefix_seen = 1'b1;
               return 1'b1;
            end
            if ((k & CODE_MASK) == KEY_LSHIFT || (k & CODE_MASK) == KEY_RSHIFT) begin
               shift_held  = 1'b0;
               prefix_seen = 1'b0;
               return 1'b1;
            end
            return 1'b0;
         end
         if (k == KEY_LSHIFT || k == KEY_RSHIFT) begin
            shift_held  = 1'b1;
            prefix_seen = 1'b0;
         end else if (k == KEY_NUM) begin
            numlock_on = !numlock_on;
         end else if (k == KEY_CAPS) begin
            caps_on = !caps_on;
         end else if (k >= PAD_FIRST && k <= PAD_LAST) begin
            c = KEYPAD_CHARS[k - PAD_FIRST];
            push_char((c >= CH_ZERO && c <= CH_NINE && !numlock_on) ? c : 8'h00);
            prefix_seen = 1'b0;
         end else if (is_printable(k)) begin
            if (prefix_seen && k == KEY_SLASH)
               c = CH_SLASH;
            else if (prefix_seen && k == KEY_ENTER)
               c = CH_NEWLINE;
            else
               c = layout_char(k);
            push_char(c);
            prefix_seen = 1'b0;
         end else begin
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: rsp transfer with no read pending, char_out %h was_empty %b",
                     $time, got.char_out, got.was_empty);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.char_out !== want.char_out) begin
            $display("%0t: char_out expected %h actual %h", $time, want.char_out,
                     got.char_out);
            errors++;
         end
         if (got.was_empty !== want.was_empty) begin
            $display("%0t: was_empty expected %b actual %b", $time, want.was_empty,
                     got.was_empty);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   logic        no_idle;
   logic        hold_rsp;
   int unsigned effective_items;
   int unsigned stalled_cycles;
   char_fifo_scoreboard sb;

   scancode_to_char_fifo_unit #(.FIFO_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_req(input req_type item);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (sb.note_request(item)) effective_items++;
   endtask

   task automatic send_scan(input logic [7:0] k);
      req_type item;
      item.kind      = KIND_SCAN;
      item.scan_code = k;
      send_req(item);
   endtask

   task automatic send_read();
      req_type item;
      item.kind      = KIND_READ;
      item.scan_code = 8'($urandom_range(255));
      send_req(item);
   endtask

   // Drop valid, wait out every pending read, then let in-flight pushes settle.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_language(input logic value);
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.language = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_key();
      int k;
      if ($urandom_range(3) == 0) return 8'($urandom_range(PAD_FIRST, PAD_LAST));
      do k = $urandom_range(2, KEY_ANGLE); while (!is_printable(k));
      return k[7:0];
   endfunction

   task automatic random_keystrokes(input int unsigned count);
      int unsigned stop_at;
      int unsigned r;
      logic [7:0]  k;
      req_type     noise;
      stop_at = effective_items + count;
      while (effective_items < stop_at) begin
         r = $urandom_range(99);
         if (r < 30) begin
            repeat ($urandom_range(1, 3)) send_read();
         end else if (r < 55) begin
            k = pick_key();
            send_scan(k);
            if ($urandom_range(1)) send_scan(k | RELEASE_BIT);
         end else if (r < 65) begin
            send_scan($urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT);
            repeat ($urandom_range(1, 3)) send_scan(pick_key());
            if ($urandom_range(4) != 0)
               send_scan(($urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT) | RELEASE_BIT);
         end else if (r < 72) begin
            send_scan(KEY_PREFIX);
            case ($urandom_range(3))
               0: send_scan(KEY_SLASH);
               1: send_scan(KEY_ENTER);
               2: send_scan(pick_key());
               default: send_scan(8'($urandom_range(255)));
            endcase
         end else if (r < 78) begin
            k = $urandom_range(1) ? KEY_CAPS : KEY_NUM;
            send_scan(k);
            send_scan(k | RELEASE_BIT);
         end else if (r < 92) begin
            send_scan(8'($urandom_range(255)));
         end else begin
            noise = 9'($urandom_range(511));
            send_req(noise);
         end
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_data        = 1'b0;
      no_idle         = 1'b0;
      hold_rsp        = 1'b0;
      effective_items = 0;
      stalled_cycles  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_language(1'b0);
      send_read();
      foreach (DIRECTED_CODES[i]) send_scan(DIRECTED_CODES[i]);
      repeat (11) send_read();

      write_language(1'b1);
      random_keystrokes(PHASE_ITEMS);
      write_language(1'b0);
      no_idle = 1'b1;
      random_keystrokes(PHASE_ITEMS);
      no_idle = 1'b0;
      write_language(1'b1);
      random_keystrokes(PHASE_ITEMS);

      // hold rsp so reads back up and req stalls
      hold_rsp = 1'b1;
      repeat (PRESSURE_ITEMS) begin
         if ($urandom_range(99) < 70)
            send_read();
         else
            send_scan(pick_key());
      end

      write_language(1'b0);
      random_keystrokes(PHASE_ITEMS);

      // drain, then overfill the ring until the pointers meet
      while (sb.rd_ptr != sb.wr_ptr) send_read();
      repeat (DEPTH) send_scan(pick_key());
      send_read();
      repeat (2) send_scan(pick_key());
      repeat (3) send_read();

      wait_quiet();
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
